>>> rtl/core/assert_macros.svh
// assertion macros used by the prefetcher top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every clock outside reset
`define RBSP_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RBSP_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/rbsp_pkg.sv
// shared types and constants of the batched ring stream prefetcher
package rbsp_pkg;

   localparam int MAX_BATCHES_DEF = 64;
   localparam int MAX_SLOTS_DEF   = 4096;

   localparam int ADDR_W  = 48;
   localparam int SIZE_W  = 13;
   localparam int LIMIT_W = 32;
   localparam int INDEX_W = 32;
   localparam int SLOT_W  = 12;
   localparam int DONE_W  = 6;
   localparam int CSR_IDX_W = 3;

   // register reset values
   localparam logic [ADDR_W-1:0]  RST_REMOTE_BASE    = '0;
   localparam logic [SIZE_W-1:0]  RST_UNIT_BYTES     = 13'd8;
   localparam logic [SIZE_W-1:0]  RST_RING_SLOTS     = 13'd64;
   localparam logic [SIZE_W-1:0]  RST_BATCH_SIZE     = 13'd16;
   localparam logic [SIZE_W-1:0]  RST_FETCH_DISTANCE = 13'd32;
   localparam logic [LIMIT_W-1:0] RST_ELEMENT_LIMIT  = '0;

   typedef enum logic [1:0] {
      BATCH_IDLE  = 2'd0,
      BATCH_SYNC  = 2'd1,
      BATCH_READY = 2'd2
   } status_type;

   localparam logic XFER_READ  = 1'b0;
   localparam logic XFER_EVICT = 1'b1;

   typedef enum logic [1:0] {
      OP_ACCESS   = 2'd0,
      OP_COMPLETE = 2'd1,
      OP_RECHECK  = 2'd2
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REMOTE_BASE    = 3'd0,
      CSR_UNIT_BYTES     = 3'd1,
      CSR_RING_SLOTS     = 3'd2,
      CSR_BATCH_SIZE     = 3'd3,
      CSR_FETCH_DISTANCE = 3'd4,
      CSR_ELEMENT_LIMIT  = 3'd5,
      CSR_IS_STORE       = 3'd6
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ALN,
      S_TSLOT,
      S_TB1,
      S_TB2,
      S_TMOD,
      S_TRD,
      S_TREQ,
      S_RSLOT,
      S_RB1,
      S_RB2,
      S_RMOD,
      S_RRD,
      S_RREP
   } state_type;

   // handshake between sequencer and divider
   typedef struct packed {
      logic start;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage

>>> rtl/core/rbsp_div.sv
// restoring divider, one quotient bit per cycle
module rbsp_div
   import rbsp_pkg::*;
#(
   parameter int DVW = 17
) (
   input  logic              clock,
   input  logic              reset,
   input  div_ctl_type       ctl,
   input  logic [INDEX_W-1:0] dividend,
   input  logic [DVW-1:0]    divisor,
   output div_sts_type       sts,
   output logic [INDEX_W-1:0] quot,
   output logic [DVW-1:0]    rem
);

   localparam int CNT_W = $clog2(INDEX_W + 1);

   logic [INDEX_W-1:0] quot_ff, quot_in;
   logic [DVW-1:0]     rem_ff, rem_in;
   logic [DVW-1:0]     dsr_ff, dsr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [DVW:0]       trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quot_ff[INDEX_W-1]};
      if (ctl.start) begin
         quot_in = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CNT_W'(INDEX_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in  = DVW'(trial - {1'b0, dsr_ff});
            quot_in = {quot_ff[INDEX_W-2:0], 1'b1};
         end else begin
            rem_in  = trial[DVW-1:0];
            quot_in = {quot_ff[INDEX_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quot     = quot_ff;
   assign rem      = rem_ff;

endmodule

>>> rtl/core/batched_ring_stream_prefetcher.sv
// top level of the batched ring stream prefetcher
//
// req_ channel carries one transaction: op, elem_index, done_batch. an access
// (op 0) with a batch-aligned index whose target lies below element_limit
// produces a remote request (last=0) and then the access reply (last=1); an
// access without prefetch and a recheck (op 2) produce the reply alone. a
// completion (op 1) marks a batch ready and produces nothing, as does op 3.
// csr_ writes one register per transaction and is always ready; write it only
// while the block is idle.
// the divisions of the index math run through one restoring divider, one
// quotient bit per cycle; the sequencer starts a new division only once the
// one before it is done. a recheck needs two divisions, an access without
// prefetch three; a prefetching access needs five divisions and shows its
// request before its reply. the next transaction is accepted in the cycle
// after the reply is loaded; a completion or op 3 leaves the block idle.
// the result sits in an output register; when rsp_ready is low the sequencer
// waits with the next result and req_ready stays low until the last one is
// loaded. reset clears the registers to their defaults and every batch to idle
// through per-batch valid bits; the block is ready the cycle after reset.
module batched_ring_stream_prefetcher
   import rbsp_pkg::*;
#(
   parameter int MAX_BATCHES = MAX_BATCHES_DEF,
   parameter int MAX_SLOTS   = MAX_SLOTS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_op,
   input  logic [INDEX_W-1:0]   req_elem_index,
   input  logic [DONE_W-1:0]    req_done_batch,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_is_request,
   output logic                 rsp_ready_res,
   output logic [SLOT_W-1:0]    rsp_slot_index,
   output logic                 rsp_req_evict,
   output logic [ADDR_W-1:0]    rsp_read_addr,
   output logic [ADDR_W-1:0]    rsp_write_addr,
   output logic [SIZE_W-1:0]    rsp_read_count,
   output logic [SIZE_W-1:0]    rsp_write_count,
   output logic                 rsp_last,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0]    csr_data
);

`include "assert_macros.svh"

   localparam int BW  = (MAX_BATCHES > 1) ? $clog2(MAX_BATCHES) : 1;
   localparam int SW  = $clog2(MAX_SLOTS + 1);
   localparam int MBW = $clog2(MAX_BATCHES + 1);
   localparam int DVW = (SW > MBW) ? SW : MBW;

   // batch number mod MAX_BATCHES by reciprocal multiplication
   localparam int ML = (MAX_BATCHES > 1) ? $clog2(MAX_BATCHES) : 0;
   localparam int RW = SW + 2;
   localparam int PW = SW + RW;
   localparam longint MB_RECIP_L =
      ((longint'(1) << (SW + ML)) + longint'(MAX_BATCHES) - 1) / longint'(MAX_BATCHES);
   localparam logic [RW-1:0] MB_RECIP = RW'(MB_RECIP_L);
   localparam logic [PW-1:0] MB_K     = PW'(MAX_BATCHES);

   // configuration registers
   logic [ADDR_W-1:0]  remote_base_ff;
   logic [SIZE_W-1:0]  unit_bytes_ff;
   logic [SIZE_W-1:0]  ring_slots_ff;
   logic [SIZE_W-1:0]  batch_size_ff;
   logic [SIZE_W-1:0]  fetch_distance_ff;
   logic [LIMIT_W-1:0] element_limit_ff;
   logic               is_store_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         remote_base_ff    <= RST_REMOTE_BASE;
         unit_bytes_ff     <= RST_UNIT_BYTES;
         ring_slots_ff     <= RST_RING_SLOTS;
         batch_size_ff     <= RST_BATCH_SIZE;
         fetch_distance_ff <= RST_FETCH_DISTANCE;
         element_limit_ff  <= RST_ELEMENT_LIMIT;
         is_store_ff       <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_REMOTE_BASE:    remote_base_ff    <= csr_data;
            CSR_UNIT_BYTES:     unit_bytes_ff     <= csr_data[SIZE_W-1:0];
            CSR_RING_SLOTS:     ring_slots_ff     <= csr_data[SIZE_W-1:0];
            CSR_BATCH_SIZE:     batch_size_ff     <= csr_data[SIZE_W-1:0];
            CSR_FETCH_DISTANCE: fetch_distance_ff <= csr_data[SIZE_W-1:0];
            CSR_ELEMENT_LIMIT:  element_limit_ff  <= csr_data[LIMIT_W-1:0];
            CSR_IS_STORE:       is_store_ff       <= csr_data[0];
            default: ;
         endcase
      end
   end

   // clamped sizes
   logic [31:0]   ring32, bat32;
   logic [SW-1:0] slots_eff, bat_eff;

   always_comb begin
      ring32 = {19'b0, ring_slots_ff};
      bat32  = {19'b0, batch_size_ff};
      if (ring32 == 32'd0)
         slots_eff = SW'(1);
      else if (ring32 > 32'(MAX_SLOTS))
         slots_eff = SW'(MAX_SLOTS);
      else
         slots_eff = SW'(ring32);
      if (bat32 == 32'd0)
         bat_eff = SW'(1);
      else if (bat32 > 32'(MAX_SLOTS))
         bat_eff = SW'(MAX_SLOTS);
      else
         bat_eff = SW'(bat32);
   end

   // transaction state
   state_type          state_ff, state_in;
   logic [INDEX_W-1:0] idx_ff;
   logic [INDEX_W:0]   tgt_ff;
   logic               pref_ff;
   logic [BW-1:0]      tb_ff, tb_in;
   logic [DVW-1:0]     slot_ff, slot_in;
   logic [SW-1:0]      bq_ff, bq_in;
   logic [SW-1:0]      mbq_ff;
   logic [PW-1:0]      mb_prod;
   logic [PW-1:0]      mb_sub;

   // quotient of the batch number by MAX_BATCHES, registered in the cycle after bq_ff
   assign mb_prod = PW'(bq_ff) * PW'(MB_RECIP);
   assign mb_sub  = PW'(bq_ff) - PW'(mbq_ff) * MB_K;

   always_ff @(posedge clock) begin
      mbq_ff <= SW'(mb_prod >> (SW + ML));
   end

   // address pipeline, inputs stay stable for the whole transaction
   logic [SIZE_W+INDEX_W-1:0] mul_ra_ff;
   logic [SIZE_W+SW-1:0]      mul_ev_ff;
   logic [ADDR_W-1:0]         ra_ff;
   logic [ADDR_W-1:0]         wa_ff;

   always_ff @(posedge clock) begin
      mul_ra_ff <= unit_bytes_ff * tgt_ff[INDEX_W-1:0];
      mul_ev_ff <= unit_bytes_ff * slots_eff;
      ra_ff     <= remote_base_ff + ADDR_W'(mul_ra_ff);
      wa_ff     <= ra_ff - ADDR_W'(mul_ev_ff);
   end

   // batch status memory with per-batch valid bits
   logic [1:0]             status_mem [MAX_BATCHES];
   logic [MAX_BATCHES-1:0] vld_ff;
   logic                   wr_en;
   logic [BW-1:0]          wr_addr;
   status_type             wr_data;
   logic [1:0]             rd_ff;
   logic                   rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en)
         status_mem[wr_addr] <= wr_data;
      rd_ff     <= status_mem[tb_ff];
      rd_vld_ff <= vld_ff[tb_ff];
   end

   always_ff @(posedge clock) begin
      if (reset)
         vld_ff <= '0;
      else if (wr_en)
         vld_ff[wr_addr] <= 1'b1;
   end

   // shared divider
   div_ctl_type        dctl;
   div_sts_type        dsts;
   logic [INDEX_W-1:0] div_dividend, div_quot;
   logic [DVW-1:0]     div_divisor, div_rem;

   rbsp_div #(.DVW(DVW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (dctl),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .sts      (dsts),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   // output register
   logic               rsp_valid_ff;
   logic               out_load;
   logic               out_free;
   logic               o_req, o_rdy, o_ev, o_last;
   logic [SLOT_W-1:0]  o_slot;
   logic [ADDR_W-1:0]  o_ra, o_wa;
   logic [SIZE_W-1:0]  o_rc, o_wc;
   logic [LIMIT_W-1:0] left;
   logic [LIMIT_W-1:0] cnt;
   logic               accept;
   logic               evict;
   logic [INDEX_W:0]   tgt_new;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign tgt_new   = {1'b0, req_elem_index} + {20'b0, fetch_distance_ff};

   always_comb begin
      state_in     = state_ff;
      dctl.start   = 1'b0;
      div_dividend = idx_ff;
      div_divisor  = DVW'(bat_eff);
      tb_in        = tb_ff;
      slot_in      = slot_ff;
      bq_in        = bq_ff;
      wr_en        = 1'b0;
      wr_addr      = tb_ff;
      wr_data      = BATCH_SYNC;
      out_load     = 1'b0;
      o_req        = 1'b0;
      o_rdy        = 1'b0;
      o_ev         = XFER_READ;
      o_slot       = SLOT_W'(slot_ff);
      o_ra         = '0;
      o_wa         = '0;
      o_rc         = '0;
      o_wc         = '0;
      o_last       = 1'b1;
      left         = element_limit_ff - tgt_ff[LIMIT_W-1:0];
      cnt          = (left < 32'(bat_eff)) ? left : 32'(bat_eff);
      evict        = is_store_ff && rd_vld_ff && (rd_ff != BATCH_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_op)
                  OP_ACCESS: begin
                     dctl.start   = 1'b1;
                     div_dividend = req_elem_index;
                     div_divisor  = DVW'(bat_eff);
                     state_in     = S_ALN;
                  end
                  OP_RECHECK: begin
                     dctl.start   = 1'b1;
                     div_dividend = req_elem_index;
                     div_divisor  = DVW'(slots_eff);
                     state_in     = S_RSLOT;
                  end
                  OP_COMPLETE: begin
                     if (32'(req_done_batch) < 32'(MAX_BATCHES)) begin
                        wr_en   = 1'b1;
                        wr_addr = BW'(req_done_batch);
                        wr_data = BATCH_READY;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_ALN: begin
            if (dsts.done) begin
               dctl.start  = 1'b1;
               div_divisor = DVW'(slots_eff);
               if (div_rem == '0 && pref_ff) begin
                  div_dividend = tgt_ff[INDEX_W-1:0];
                  state_in     = S_TSLOT;
               end else begin
                  div_dividend = idx_ff;
                  state_in     = S_RSLOT;
               end
            end
         end
         S_TSLOT, S_RSLOT: begin
            if (dsts.done) begin
               slot_in      = div_rem;
               dctl.start   = 1'b1;
               div_dividend = INDEX_W'(div_rem);
               div_divisor  = DVW'(bat_eff);
               state_in     = (state_ff == S_TSLOT) ? S_TB1 : S_RB1;
            end
         end
         S_TB1, S_RB1: begin
            if (dsts.done) begin
               bq_in    = div_quot[SW-1:0];
               state_in = (state_ff == S_TB1) ? S_TB2 : S_RB2;
            end
         end
         S_TB2: state_in = S_TMOD;
         S_RB2: state_in = S_RMOD;
         S_TMOD, S_RMOD: begin
            // batch number taken mod the batch count
            tb_in    = BW'(mb_sub);
            state_in = (state_ff == S_TMOD) ? S_TRD : S_RRD;
         end
         S_TRD: state_in = S_TREQ;
         S_RRD: state_in = S_RREP;
         S_TREQ: begin
            if (out_free) begin
               out_load = 1'b1;
               o_req    = 1'b1;
               o_ev     = evict ? XFER_EVICT : XFER_READ;
               o_ra     = ra_ff;
               o_wa     = evict ? wa_ff : '0;
               o_rc     = cnt[SIZE_W-1:0];
               o_wc     = evict ? SIZE_W'(bat_eff) : '0;
               o_last   = 1'b0;
               wr_en    = 1'b1;
               wr_addr  = tb_ff;
               wr_data  = BATCH_SYNC;
               dctl.start   = 1'b1;
               div_dividend = idx_ff;
               div_divisor  = DVW'(slots_eff);
               state_in     = S_RSLOT;
            end
         end
         S_RREP: begin
            if (out_free) begin
               out_load = 1'b1;
               o_rdy    = rd_vld_ff && (rd_ff == BATCH_READY);
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= S_IDLE;
      else
         state_ff <= state_in;
      tb_ff   <= tb_in;
      slot_ff <= slot_in;
      bq_ff   <= bq_in;
      if (accept) begin
         idx_ff  <= req_elem_index;
         tgt_ff  <= tgt_new;
         pref_ff <= (tgt_new < {1'b0, element_limit_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (out_load)
         rsp_valid_ff <= 1'b1;
      else if (rsp_ready)
         rsp_valid_ff <= 1'b0;
      if (out_load) begin
         rsp_is_request  <= o_req;
         rsp_ready_res   <= o_rdy;
         rsp_slot_index  <= o_slot;
         rsp_req_evict   <= o_ev;
         rsp_read_addr   <= o_ra;
         rsp_write_addr  <= o_wa;
         rsp_read_count  <= o_rc;
         rsp_write_count <= o_wc;
         rsp_last        <= o_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `RBSP_ASSERT_IMP(a_req_not_last, rsp_valid && rsp_is_request, !rsp_last, "request marked last")
   `RBSP_ASSERT_IMP(a_reply_last, rsp_valid && !rsp_is_request, rsp_last, "reply not marked last")
   `RBSP_ASSERT_IMP(a_div_idle, state_ff == S_IDLE, !dsts.busy, "divider busy while idle")
   `RBSP_ASSERT_NXT(a_load_valid, out_load, rsp_valid, "loaded result not shown")

endmodule

>>> tb/sv/batched_ring_stream_prefetcher_checker.sv
// checker: predicts the prefetcher's results from the observed transactions and compares
module batched_ring_stream_prefetcher_checker
   import rbsp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic [1:0]           req_op,
   input  logic [INDEX_W-1:0]   req_elem_index,
   input  logic [DONE_W-1:0]    req_done_batch,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic                 rsp_is_request,
   input  logic                 rsp_ready_res,
   input  logic [SLOT_W-1:0]    rsp_slot_index,
   input  logic                 rsp_req_evict,
   input  logic [ADDR_W-1:0]    rsp_read_addr,
   input  logic [ADDR_W-1:0]    rsp_write_addr,
   input  logic [SIZE_W-1:0]    rsp_read_count,
   input  logic [SIZE_W-1:0]    rsp_write_count,
   input  logic                 rsp_last,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0]    csr_data,
   output int                   pending,
   output int                   errors
);

   localparam int NUM_BATCHES = MAX_BATCHES_DEF;
   localparam logic [63:0] ADDR_MASK = 64'hFFFF_FFFF_FFFF;

   typedef struct {
      logic              is_request;
      logic              ready_res;
      logic [SLOT_W-1:0] slot_index;
      logic              req_evict;
      logic [ADDR_W-1:0] read_addr;
      logic [ADDR_W-1:0] write_addr;
      logic [SIZE_W-1:0] read_count;
      logic [SIZE_W-1:0] write_count;
      logic              last;
   } ring_result_type;

   ring_result_type expected_results[$];
   status_type      batch_state[NUM_BATCHES];

   logic [ADDR_W-1:0]  remote_base;
   logic [SIZE_W-1:0]  unit_bytes;
   logic [SIZE_W-1:0]  ring_slots;
   logic [SIZE_W-1:0]  batch_size;
   logic [SIZE_W-1:0]  fetch_distance;
   logic [LIMIT_W-1:0] element_limit;
   logic               is_store;

   assign pending = expected_results.size();

   function automatic logic [63:0] clamp_size(logic [SIZE_W-1:0] v);
      logic [63:0] r;
      r = 64'(v);
      if (r < 1) r = 1;
      if (r > MAX_SLOTS_DEF) r = MAX_SLOTS_DEF;
      return r;
   endfunction

   function automatic void predict_prefetch(logic [1:0] op, logic [INDEX_W-1:0] elem,
                                            logic [DONE_W-1:0] done);
      logic [63:0] slots, bat, idx, tgt, left, cnt, tslot, tb, ra, wa, wc, slot, b;
      logic ev;
      ring_result_type r;
      slots = clamp_size(ring_slots);
      bat = clamp_size(batch_size);
      idx = 64'(elem);
      if (op == OP_COMPLETE) begin
         if (done < NUM_BATCHES) batch_state[done] = BATCH_READY;
         return;
      end
      if (op != OP_ACCESS && op != OP_RECHECK) return;
      if (op == OP_ACCESS && (idx % bat) == 0 && idx + fetch_distance < element_limit) begin
         tgt = idx + fetch_distance;
         left = element_limit - tgt;
         cnt = left < bat ? left : bat;
         tslot = tgt % slots;
         tb = (tslot / bat) % NUM_BATCHES;
         ra = (remote_base + unit_bytes * tgt) & ADDR_MASK;
         ev = XFER_READ;
         wa = 0;
         wc = 0;
         if (is_store && batch_state[tb] != BATCH_IDLE) begin
            ev = XFER_EVICT;
            wa = (ra - unit_bytes * slots) & ADDR_MASK;
            wc = bat;
         end
         batch_state[tb] = BATCH_SYNC;
         r = '{1'b1, 1'b0, tslot[SLOT_W-1:0], ev, ra[ADDR_W-1:0], wa[ADDR_W-1:0],
               cnt[SIZE_W-1:0], wc[SIZE_W-1:0], 1'b0};
         expected_results.push_back(r);
      end
      slot = idx % slots;
      b = (slot / bat) % NUM_BATCHES;
      r = '{1'b0, batch_state[b] == BATCH_READY, slot[SLOT_W-1:0], 1'b0, '0, '0,
            '0, '0, 1'b1};
      expected_results.push_back(r);
   endfunction

   function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      ring_result_type e;
      if (reset) begin
         expected_results.delete();
         foreach (batch_state[i]) batch_state[i] = BATCH_IDLE;
         remote_base    = RST_REMOTE_BASE;
         unit_bytes     = RST_UNIT_BYTES;
         ring_slots     = RST_RING_SLOTS;
         batch_size     = RST_BATCH_SIZE;
         fetch_distance = RST_FETCH_DISTANCE;
         element_limit  = RST_ELEMENT_LIMIT;
         is_store       = 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_REMOTE_BASE:    remote_base = csr_data;
               CSR_UNIT_BYTES:     unit_bytes = csr_data[SIZE_W-1:0];
               CSR_RING_SLOTS:     ring_slots = csr_data[SIZE_W-1:0];
               CSR_BATCH_SIZE:     batch_size = csr_data[SIZE_W-1:0];
               CSR_FETCH_DISTANCE: fetch_distance = csr_data[SIZE_W-1:0];
               CSR_ELEMENT_LIMIT:  element_limit = csr_data[LIMIT_W-1:0];
               CSR_IS_STORE:       is_store = csr_data[0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $error("result transaction with no expected result waiting");
               errors++;
            end else begin
               e = expected_results.pop_front();
               check_field("is_request", e.is_request, rsp_is_request);
               check_field("ready_res", e.ready_res, rsp_ready_res);
               check_field("slot_index", e.slot_index, rsp_slot_index);
               check_field("req_evict", e.req_evict, rsp_req_evict);
               check_field("read_addr", e.read_addr, rsp_read_addr);
               check_field("write_addr", e.write_addr, rsp_write_addr);
               check_field("read_count", e.read_count, rsp_read_count);
               check_field("write_count", e.write_count, rsp_write_count);
               check_field("last", e.last, rsp_last);
            end
         end
         if (req_valid && req_ready) predict_prefetch(req_op, req_elem_index, req_done_batch);
      end
   end

   initial errors = 0;

endmodule

>>> tb/sv/batched_ring_stream_prefetcher_tb.sv
// testbench top: stimulus for the batched ring stream prefetcher and the final verdict
module batched_ring_stream_prefetcher_tb;
   import rbsp_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 300;
   localparam int WATCHDOG_LIMIT = 3000;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [1:0]           req_op;
   logic [INDEX_W-1:0]   req_elem_index;
   logic [DONE_W-1:0]    req_done_batch;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic                 rsp_is_request;
   logic                 rsp_ready_res;
   logic [SLOT_W-1:0]    rsp_slot_index;
   logic                 rsp_req_evict;
   logic [ADDR_W-1:0]    rsp_read_addr;
   logic [ADDR_W-1:0]    rsp_write_addr;
   logic [SIZE_W-1:0]    rsp_read_count;
   logic [SIZE_W-1:0]    rsp_write_count;
   logic                 rsp_last;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [ADDR_W-1:0]    csr_data;
   int                   pending;
   int                   errors;
   int                   quiet_cycles;
   bit                   send_burst;
   bit                   drain_burst;

   batched_ring_stream_prefetcher DUT (.*);

   batched_ring_stream_prefetcher_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // result side stalls
   initial begin
      int n;
      rsp_ready = 1'b0;
      drain_burst = 1'b0;
      @(negedge reset);
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 31) == 0) drain_burst = !drain_burst;
         n = drain_burst ? 0 : $urandom_range(0, 7);
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   task automatic write_reg(csr_index_type idx, logic [ADDR_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!(csr_valid && csr_ready));
   endtask

   task automatic wait_drained();
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(logic [ADDR_W-1:0] base, logic [SIZE_W-1:0] unit,
                            logic [SIZE_W-1:0] slots, logic [SIZE_W-1:0] bat,
                            logic [SIZE_W-1:0] ahead, logic [LIMIT_W-1:0] limit,
                            logic store);
      // no input transaction may stay offered while the registers change
      req_valid <= 1'b0;
      wait_drained();
      write_reg(CSR_REMOTE_BASE, base);
      write_reg(CSR_UNIT_BYTES, ADDR_W'(unit));
      write_reg(CSR_RING_SLOTS, ADDR_W'(slots));
      write_reg(CSR_BATCH_SIZE, ADDR_W'(bat));
      write_reg(CSR_FETCH_DISTANCE, ADDR_W'(ahead));
      write_reg(CSR_ELEMENT_LIMIT, ADDR_W'(limit));
      write_reg(CSR_IS_STORE, ADDR_W'(store));
      csr_valid <= 1'b0;
   endtask

   task automatic send_item(logic [1:0] op, logic [INDEX_W-1:0] idx, logic [DONE_W-1:0] done);
      int n;
      if ($urandom_range(0, 31) == 0) send_burst = !send_burst;
      n = send_burst ? 0 : $urandom_range(0, 7);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_elem_index <= idx;
      req_done_batch <= done;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   initial begin
      int unsigned bat, slots, ahead, start, limit;
      logic [INDEX_W-1:0] cursor;
      int sel;
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = OP_ACCESS;
      req_elem_index = '0;
      req_done_batch = '0;
      csr_valid = 1'b0;
      csr_index = CSR_REMOTE_BASE;
      csr_data = '0;
      send_burst = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // defaults: limit zero, so no prefetch
      send_item(OP_ACCESS, '0, '0);
      send_item(OP_UNUSED, 32'hFFFF_FFFF, 6'h3F);
      send_item(OP_RECHECK, 32'd5, '0);
      send_item(OP_COMPLETE, '0, '0);
      send_item(OP_RECHECK, 32'd3, '0);
      // all maximal, store ring: second access to the same batch evicts
      configure(48'hFFFF_FFFF_FFFF, 13'd4096, 13'd4096, 13'd4096, 13'd4096,
                32'hFFFF_FFFF, 1'b1);
      send_item(OP_ACCESS, '0, '0);
      send_item(OP_ACCESS, '0, '0);
      send_item(OP_ACCESS, 32'hFFFF_F000, '0);
      send_item(OP_ACCESS, 32'hFFFF_FFFF, '0);
      send_item(OP_COMPLETE, '0, 6'h3F);
      send_item(OP_COMPLETE, '0, '0);
      send_item(OP_RECHECK, 32'h0000_0FFF, '0);
      // zero sizes clamp to one; eviction address wraps below zero
      configure(48'h0, 13'd1, 13'd0, 13'd0, 13'd0, 32'd5, 1'b1);
      send_item(OP_ACCESS, '0, '0);
      send_item(OP_ACCESS, '0, '0);
      send_item(OP_ACCESS, 32'd4, '0);
      // oversized sizes clamp to the slot maximum
      configure(48'h0000_1234_5678, 13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF, 32'd100000, 1'b0);
      send_item(OP_ACCESS, '0, '0);
      send_item(OP_ACCESS, 32'd8192, '0);
      // short last batch near the limit
      configure(48'hABCD_0000_0000, 13'd3, 13'd12, 13'd4, 13'd4, 32'd10, 1'b0);
      send_item(OP_ACCESS, 32'd4, '0);
      send_item(OP_COMPLETE, '0, 6'd2);
      send_item(OP_RECHECK, 32'd8, '0);

      for (int phase = 0; phase < 10; phase++) begin
         bat = 1 << $urandom_range(0, 5);
         if ($urandom_range(0, 3) == 0) bat = $urandom_range(1, 64);
         slots = bat * $urandom_range(1, 8);
         ahead = bat * $urandom_range(0, 4);
         start = bat * $urandom_range(0, 1000);
         limit = start + $urandom_range(0, 40 * bat + ahead);
         if (phase == 9) limit = 32'hFFFF_FFFF;
         configure(ADDR_W'({$urandom, $urandom}), SIZE_W'($urandom_range(1, 4096)),
                   SIZE_W'(slots), SIZE_W'(bat), SIZE_W'(ahead), limit, phase[0]);
         cursor = start;
         for (int k = 0; k < 125; k++) begin
            sel = $urandom_range(0, 99);
            if (k == 60 && phase == 3) begin
               // sender pauses until every expected result has come
               req_valid <= 1'b0;
               do @(posedge clock); while (pending != 0);
            end
            if (sel < 50) begin
               send_item(OP_ACCESS, cursor, DONE_W'($urandom));
               cursor = cursor + 32'd1;
            end else if (sel < 70) begin
               send_item(OP_COMPLETE, $urandom,
                         DONE_W'((((cursor + ahead) % slots) / bat) % 64));
            end else if (sel < 75) begin
               send_item(OP_COMPLETE, $urandom, DONE_W'($urandom));
            end else if (sel < 87) begin
               send_item(OP_RECHECK, cursor - $urandom_range(0, 2 * bat), DONE_W'($urandom));
            end else if (sel < 96) begin
               send_item($urandom_range(0, 1) ? OP_ACCESS : OP_RECHECK, $urandom,
                         DONE_W'($urandom));
            end else begin
               send_item(OP_UNUSED, $urandom, DONE_W'($urandom));
            end
         end
      end
      req_valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
